FILE: sv/lrut_pkg.sv
// ----------------------------------------------------------------------------
// lrut_pkg: shared types and constants for the LRU cache hit tracker
// Sizes, cell-to-cell scan word, broadcast and update words, FSM states.
// ----------------------------------------------------------------------------
`default_nettype none

package lrut_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int CFG_W   = 5;
    localparam int ADDR_W  = 32;
    localparam int TOT_W   = 32;
    localparam int ACT_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

    localparam int OUT_BITS = 2 + ADDR_W + 2 * TOT_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_state;

    // request data seen by every cell during a scan
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [ACT_W-1:0]  searched;
        logic [ACT_W-1:0]  active;
    } t_bcast;

    // partial result handed from one cell to the next
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] hit_id;
        logic             vic_vld;
        logic [IDX_W-1:0] vic_rank;
        logic [IDX_W-1:0] vic_id;
    } t_scan;

    // state change applied by all cells at the end of an item
    typedef struct packed {
        logic              promote;
        logic              we;
        logic [IDX_W-1:0]  where;
        logic [IDX_W-1:0]  prank;
        logic [ADDR_W-1:0] addr;
    } t_upd;

endpackage

`default_nettype wire

FILE: sv/lrut_cell.sv
// ----------------------------------------------------------------------------
// lrut_cell: one cache entry
// Holds a stored address and its recency rank; folds its own match and
// replacement candidacy into the scan word passed on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module lrut_cell
    import lrut_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [IDX_W-1:0]  i_id,
    input  wire t_bcast            i_bc,
    input  wire t_scan             i_scan,
    input  wire t_upd              i_upd,
    output t_scan                  o_scan,
    output logic [IDX_W-1:0]       o_rank,
    output logic [ADDR_W-1:0]      o_addr
);

    logic [ADDR_W-1:0] r_addr;
    logic [IDX_W-1:0]  r_rank;
    t_scan             r_scan;
    t_scan             n_scan;
    logic              w_match;
    logic              w_elig;

    assign w_match = (ACT_W'(i_id) < i_bc.searched) && (r_addr == i_bc.addr);
    assign w_elig  = (ACT_W'(i_id) < i_bc.active);

    always_comb begin
        n_scan = i_scan;
        if (!i_scan.found && w_match) begin
            n_scan.found  = 1'b1;
            n_scan.hit_id = i_id;
        end
        // oldest active entry wins
        if (w_elig && (!i_scan.vic_vld || (r_rank > i_scan.vic_rank))) begin
            n_scan.vic_vld  = 1'b1;
            n_scan.vic_rank = r_rank;
            n_scan.vic_id   = i_id;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan <= n_scan;
        if (i_upd.we && (i_upd.where == i_id)) begin
            r_addr <= i_upd.addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank <= i_id;
        end else if (i_upd.promote) begin
            if (i_upd.where == i_id) begin
                r_rank <= '0;
            end else if (r_rank < i_upd.prank) begin
                r_rank <= r_rank + 1'b1;
            end
        end
    end

    assign o_scan = r_scan;
    assign o_rank = r_rank;
    assign o_addr = r_addr;

endmodule

`default_nettype wire

FILE: sv/lru_cache_hit_tracker.sv
// ----------------------------------------------------------------------------
// lru_cache_hit_tracker: fully associative LRU cache hit/miss tracker
// Row of entry cells scanned by a wavefront, central FSM, totals, output reg.
// ----------------------------------------------------------------------------
// One request address per input transfer, one result per request. The cache
// holds up to ENTRIES addresses, one per cell; the config register sets how
// many of them are active (0 acts as 1, above ENTRIES acts as ENTRIES); it
// must be written only while the block is idle, which the block itself does
// not enforce. A request is captured, then a match/victim scan ripples through
// the cell row one cell per clock, then the hit, fill or replacement is
// committed; only then is the next input transfer taken. The result waits in
// an output register; the commit cycle stalls only while an older result is
// still untaken. Hit and miss totals saturate at all ones and survive end of
// trace (tlast); only reset clears them. No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_cache_hit_tracker
    import lrut_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // config write channel: entries_in_use
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    // request stream
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [ADDR_W-1:0] i_s_tdata,   // [31:0] request_address
    input  wire logic              i_s_tlast,   // end_of_trace
    // result stream
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    // [0] hit, [1] evicted_valid, [33:2] evicted_address,
    // [65:34] hit_total, [97:66] miss_total, [103:98] zero
    output logic [OUT_W-1:0]       o_m_tdata,
    output logic                   o_m_tlast    // trace_done
);

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_cnt;
    t_bcast            r_bc;
    logic              r_done;
    logic [CNT_W-1:0]  r_filled;
    logic [TOT_W-1:0]  r_hits, r_misses;
    logic [CFG_W-1:0]  r_cfg;
    logic              r_out_vld;
    logic [OUT_W-1:0]  r_out_data;
    logic              r_out_last;

    logic [ACT_W-1:0]  w_active;
    logic [ACT_W-1:0]  w_filled_ext;
    logic              w_in_xfer;
    logic              w_slot_free;
    logic              w_commit;
    logic              w_fill;
    logic              w_evict;
    t_scan             w_fin;
    t_upd              w_upd;
    logic [IDX_W-1:0]  w_rank_sel;
    logic [ADDR_W-1:0] w_addr_sel;
    logic [ADDR_W-1:0] w_ev_addr;
    logic [TOT_W-1:0]  w_hits_nx, w_misses_nx;

    t_scan             w_scan [ENTRIES+1];
    logic [IDX_W-1:0]  w_rank [ENTRIES];
    logic [ADDR_W-1:0] w_addr [ENTRIES];

    // ---- config --------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid) begin
            r_cfg <= i_cfg_data;
        end
    end

    // active count clamped to 1..ENTRIES
    always_comb begin
        w_active = ACT_W'(r_cfg);
        if (r_cfg == '0) begin
            w_active = ACT_W'(1);
        end else if (ACT_W'(r_cfg) > ACT_W'(ENTRIES)) begin
            w_active = ACT_W'(ENTRIES);
        end
    end

    assign w_filled_ext = ACT_W'(r_filled);

    // ---- cell row --------------------------------------------------------
    assign w_scan[0] = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lrut_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_id    (IDX_W'(g)),
            .i_bc    (r_bc),
            .i_scan  (w_scan[g]),
            .i_upd   (w_upd),
            .o_scan  (w_scan[g+1]),
            .o_rank  (w_rank[g]),
            .o_addr  (w_addr[g])
        );
    end

    assign w_fin = w_scan[ENTRIES];

    // ---- control ---------------------------------------------------------
    assign w_in_xfer   = i_s_tvalid && o_s_tready;
    assign w_slot_free = !r_out_vld || i_m_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_cnt == IDX_W'(ENTRIES - 1)) n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (w_slot_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // commit decode: hit promotes, miss fills the next free entry or
    // replaces the oldest active one; either way the chosen entry is promoted
    always_comb begin
        o_s_tready = (r_state == ST_IDLE);
        w_commit   = (r_state == ST_UPDATE) && w_slot_free;
        w_fill     = !w_fin.found && (w_filled_ext < r_bc.active);
        w_evict    = !w_fin.found && !w_fill;

        w_upd.where = w_fin.vic_id;
        if (w_fin.found) begin
            w_upd.where = w_fin.hit_id;
        end else if (w_fill) begin
            w_upd.where = r_filled[IDX_W-1:0];
        end

        // one-address read of the row for rank and victim address
        w_rank_sel = '0;
        w_addr_sel = '0;
        for (int k = 0; k < ENTRIES; k++) begin
            if (w_upd.where == IDX_W'(k)) begin
                w_rank_sel = w_rank[k];
                w_addr_sel = w_addr[k];
            end
        end

        w_upd.promote = w_commit;
        w_upd.we      = w_commit && !w_fin.found;
        w_upd.prank   = w_rank_sel;
        w_upd.addr    = r_bc.addr;

        w_ev_addr   = w_evict ? w_addr_sel : '0;
        w_hits_nx   = (w_fin.found && (r_hits != '1)) ? r_hits + 1'b1 : r_hits;
        w_misses_nx = (!w_fin.found && (r_misses != '1)) ? r_misses + 1'b1 : r_misses;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_filled  <= '0;
            r_hits    <= '0;
            r_misses  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_xfer) begin
                r_cnt <= '0;
            end else if (r_state == ST_SCAN) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (w_commit) begin
                r_hits   <= w_hits_nx;
                r_misses <= w_misses_nx;
                if (w_fill) r_filled <= r_filled + 1'b1;
            end
            if (w_commit) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // request capture and result payload
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_bc.addr     <= i_s_tdata;
            r_bc.active   <= w_active;
            r_bc.searched <= (w_filled_ext < w_active) ? w_filled_ext : w_active;
            r_done        <= i_s_tlast;
        end
        if (w_commit) begin
            r_out_data <= OUT_W'({w_misses_nx, w_hits_nx, w_ev_addr,
                                  w_evict, w_fin.found});
            r_out_last <= r_done;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire

FILE: sv/lrut_checker.sv
// ----------------------------------------------------------------------------
// lrut_checker: port-level assertions for the LRU cache hit tracker
// Bound to the top level; watches handshakes and result consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module lrut_checker
    import lrut_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_s_tvalid,
    input wire logic              o_s_tready,
    input wire logic              o_m_tvalid,
    input wire logic              i_m_tready,
    input wire logic [OUT_W-1:0]  o_m_tdata,
    input wire logic              o_m_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tlast))
        else $error("result changed while stalled");

    // one request in flight: no accept right after an accept
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("request accepted while another is in flight");

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[0] |-> !o_m_tdata[1])
        else $error("hit reported with eviction");

    // no eviction means zero evicted address
    a_ev_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[1] |-> (o_m_tdata[33:2] == '0))
        else $error("evicted address nonzero without eviction");

endmodule

bind lru_cache_hit_tracker lrut_checker u_lrut_checker (.*);

`default_nettype wire
